@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is applied.
`define PSFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PSFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/psfa_pkg.sv @@
package psfa_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// dividend: (avg - cal_low) * full_scale, divisor: calibration span
	localparam int DIV_DW = 24;
	localparam int DIV_VW = 11;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [2:0] REG_CAL_LOW    = 3'd0;
	localparam logic [2:0] REG_CAL_HIGH   = 3'd1;
	localparam logic [2:0] REG_FULL_SCALE = 3'd2;
	localparam logic [2:0] REG_SPIKE_THR  = 3'd3;
	localparam logic [2:0] REG_MAX_SPIKES = 3'd4;

	localparam logic [9:0]  CAL_LOW_RST    = 10'd209;
	localparam logic [10:0] CAL_HIGH_RST   = 11'd1060;
	localparam logic [13:0] FULL_SCALE_RST = 14'd1579;
	localparam logic [9:0]  SPIKE_THR_RST  = 10'd50;
	localparam logic [3:0]  MAX_SPIKES_RST = 4'd5;

	localparam logic [13:0] FULL_SCALE_MAX = 14'd9999;
	localparam logic [13:0] HUNDRED        = 14'd100;
	// floor(p / 100) == (p * 5243) >> 19 for every p below 10000
	localparam logic [26:0] DIV100_MUL   = 27'd5243;
	localparam int          DIV100_SHIFT = 19;

	typedef struct packed {
		logic [9:0]  cal_low;
		logic [10:0] cal_high;
		logic [13:0] full_scale;
		logic [9:0]  spike_thr;
		logic [3:0]  max_spikes;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_AVG,
		ST_MUL,
		ST_SPAN_START,
		ST_SPAN_DIV,
		ST_SPLIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic sample_commit;
		logic avg_capture;
		logic mul_load;
		logic span_start;
		logic p_capture;
		logic whole_capture;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic div_busy;
	} status_t;

endpackage

@@ sv/pressure_spike_filter_averager.sv @@
// Spike-rejecting moving average for a 4-20 mA pressure sensor on a 10-bit
// converter. A sample transaction (opcode 0) is checked against the last read
// average and either dropped as a spike or written into a RING_DEPTH-entry ring
// with a running sum. A read transaction (opcode 1) scales the ring average by
// full_scale over the calibration span with a bit-serial divider that runs 24
// steps; the ring average itself is a constant reciprocal multiply.
// The ring is held in a small memory with one valid bit per entry cleared by
// reset, so no clearing pass follows reset. A new transaction is accepted in
// the cycle after the previous one has reached the output register, even while
// that result waits to be taken. Registers sit on the APB port at byte
// addresses 0x00 cal_low, 0x04 cal_high, 0x08 full_scale, 0x0C spike_thr,
// 0x10 max_spikes, and are to be written only while no transaction is in flight.
module pressure_spike_filter_averager #(
	parameter int RING_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [psfa_pkg::ADDR_W-1:0] paddr,
	input  logic [psfa_pkg::DATA_W-1:0] pwdata,
	output logic [psfa_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic                        opcode,
	input  logic [9:0]                  sample,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        sample_dropped,
	output logic [9:0]                  average_raw,
	output logic [6:0]                  pressure_whole,
	output logic [6:0]                  pressure_hundredths
);

	psfa_pkg::cfg_t    cfg_q;
	psfa_pkg::cmd_t    cmd;
	psfa_pkg::status_t status;
	logic              wr_en;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_low    <= psfa_pkg::CAL_LOW_RST;
			cfg_q.cal_high   <= psfa_pkg::CAL_HIGH_RST;
			cfg_q.full_scale <= psfa_pkg::FULL_SCALE_RST;
			cfg_q.spike_thr  <= psfa_pkg::SPIKE_THR_RST;
			cfg_q.max_spikes <= psfa_pkg::MAX_SPIKES_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				psfa_pkg::REG_CAL_LOW:    cfg_q.cal_low    <= pwdata[9:0];
				psfa_pkg::REG_CAL_HIGH:   cfg_q.cal_high   <= pwdata[10:0];
				psfa_pkg::REG_FULL_SCALE: cfg_q.full_scale <= pwdata[13:0];
				psfa_pkg::REG_SPIKE_THR:  cfg_q.spike_thr  <= pwdata[9:0];
				psfa_pkg::REG_MAX_SPIKES: cfg_q.max_spikes <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			psfa_pkg::REG_CAL_LOW:    prdata = psfa_pkg::DATA_W'(cfg_q.cal_low);
			psfa_pkg::REG_CAL_HIGH:   prdata = psfa_pkg::DATA_W'(cfg_q.cal_high);
			psfa_pkg::REG_FULL_SCALE: prdata = psfa_pkg::DATA_W'(cfg_q.full_scale);
			psfa_pkg::REG_SPIKE_THR:  prdata = psfa_pkg::DATA_W'(cfg_q.spike_thr);
			psfa_pkg::REG_MAX_SPIKES: prdata = psfa_pkg::DATA_W'(cfg_q.max_spikes);
			default:                  prdata = '0;
		endcase
	end

	psfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.opcode   (opcode),
		.cmd_ready(cmd_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.status   (status)
	);

	psfa_datapath #(
		.RING_DEPTH(RING_DEPTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.cmd                (cmd),
		.status             (status),
		.opcode             (opcode),
		.sample             (sample),
		.sample_dropped     (sample_dropped),
		.average_raw        (average_raw),
		.pressure_whole     (pressure_whole),
		.pressure_hundredths(pressure_hundredths)
	);

endmodule

@@ sv/psfa_div.sv @@
module psfa_div #(
	parameter int DW = 24,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW);

	logic          busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic          fits;

	// restoring division, one quotient bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ sv/psfa_datapath.sv @@
module psfa_datapath #(
	parameter int RING_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psfa_pkg::cfg_t       cfg,
	input  psfa_pkg::cmd_t       cmd,
	output psfa_pkg::status_t    status,
	input  logic                 opcode,
	input  logic [9:0]           sample,
	output logic                 sample_dropped,
	output logic [9:0]           average_raw,
	output logic [6:0]           pressure_whole,
	output logic [6:0]           pressure_hundredths
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int SUM_W = $clog2(RING_DEPTH * 1023 + 1);
	// floor(sum / RING_DEPTH) by a rounded-up reciprocal, exact for every SUM_W-bit sum
	localparam int RCP_SHIFT = SUM_W + PTR_W;
	localparam int RCP_MUL   = ((1 << RCP_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
	localparam int PROD_W    = 2 * SUM_W + 1;

	// ring storage
	logic [9:0]            ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [9:0]            rd_q;
	logic                  rd_vld_q;
	logic [PTR_W-1:0]      pos_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  op_q;
	logic [9:0]            smp_q;
	logic [9:0]            ref_q;
	logic [3:0]            spk_q;
	logic                  drop_q;

	logic [9:0]            avg_q;
	logic [9:0]            diff_q;
	logic                  zero_q;
	logic [23:0]           prod_q;
	logic [13:0]           p_q;
	logic [6:0]            whole_q;

	logic                  dropped_out_q;
	logic [9:0]            avg_out_q;
	logic [6:0]            whole_out_q;
	logic [6:0]            hund_out_q;

	logic [9:0]            old_smp;
	logic [9:0]            smp_diff;
	logic                  drop;
	logic [13:0]           fs_clamp;
	logic [10:0]           span;
	logic [PROD_W-1:0]     avg_prod;
	logic [9:0]            avg;
	logic                  div_start;
	logic [psfa_pkg::DIV_DW-1:0] div_dividend;
	logic [psfa_pkg::DIV_VW-1:0] div_divisor;
	logic                  div_busy;
	logic [psfa_pkg::DIV_DW-1:0] div_quo;
	logic [26:0]           whole_wide;
	logic [13:0]           hund;

	always_comb begin
		old_smp  = rd_vld_q ? rd_q : 10'd0;
		smp_diff = (smp_q > ref_q) ? (smp_q - ref_q) : (ref_q - smp_q);
		drop     = (ref_q != 10'd0) && (smp_diff > cfg.spike_thr) && (spk_q < cfg.max_spikes);
		fs_clamp = (cfg.full_scale > psfa_pkg::FULL_SCALE_MAX) ?
			psfa_pkg::FULL_SCALE_MAX : cfg.full_scale;
		span     = cfg.cal_high - {1'b0, cfg.cal_low};
		avg_prod = PROD_W'(sum_q) * PROD_W'(RCP_MUL);
		avg      = avg_prod[RCP_SHIFT +: 10];
		div_start    = cmd.span_start;
		div_dividend = prod_q;
		div_divisor  = span;
		whole_wide   = 27'(p_q) * psfa_pkg::DIV100_MUL;
		hund         = p_q - 14'(whole_q) * psfa_pkg::HUNDRED;
	end

	psfa_div #(
		.DW(psfa_pkg::DIV_DW),
		.VW(psfa_pkg::DIV_VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	// one write and one registered read a cycle, both at the write pointer
	always_ff @(posedge clk) begin
		if (cmd.sample_commit && !drop) begin
			ring_mem[pos_q] <= smp_q;
		end
		rd_q <= ring_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			pos_q    <= '0;
			sum_q    <= '0;
			spk_q    <= '0;
			ref_q    <= '0;
		end else begin
			rd_vld_q <= vld_q[pos_q];
			if (cmd.sample_commit) begin
				if (drop) begin
					spk_q <= spk_q + 1'b1;
				end else begin
					spk_q        <= '0;
					vld_q[pos_q] <= 1'b1;
					sum_q        <= sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);
					pos_q        <= (pos_q == PTR_W'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
				end
			end
			if (cmd.avg_capture) begin
				ref_q <= avg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			smp_q <= sample;
		end
		if (cmd.sample_commit) begin
			drop_q <= drop;
		end
		if (cmd.avg_capture) begin
			avg_q  <= avg;
			diff_q <= avg - cfg.cal_low;
			zero_q <= (cfg.cal_high <= {1'b0, cfg.cal_low}) || (avg <= cfg.cal_low);
		end
		if (cmd.mul_load) begin
			prod_q <= 24'(diff_q) * 24'(fs_clamp);
		end
		if (cmd.p_capture) begin
			if (zero_q) begin
				p_q <= '0;
			end else if (div_quo > 24'(fs_clamp)) begin
				p_q <= fs_clamp;
			end else begin
				p_q <= div_quo[13:0];
			end
		end
		if (cmd.whole_capture) begin
			whole_q <= 7'(whole_wide >> psfa_pkg::DIV100_SHIFT);
		end
		if (cmd.out_load) begin
			if (op_q == psfa_pkg::OP_READ) begin
				dropped_out_q <= 1'b0;
				avg_out_q     <= avg_q;
				whole_out_q   <= whole_q;
				hund_out_q    <= hund[6:0];
			end else begin
				dropped_out_q <= drop_q;
				avg_out_q     <= '0;
				whole_out_q   <= '0;
				hund_out_q    <= '0;
			end
		end
	end

	assign status.opcode   = op_q;
	assign status.div_busy = div_busy;

	assign sample_dropped      = dropped_out_q;
	assign average_raw         = avg_out_q;
	assign pressure_whole      = whole_out_q;
	assign pressure_hundredths = hund_out_q;

endmodule

@@ sv/psfa_ctrl.sv @@
module psfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              opcode,
	output logic              cmd_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output psfa_pkg::cmd_t    cmd,
	input  psfa_pkg::status_t status
);

	psfa_pkg::state_t state_q;
	psfa_pkg::state_t state_d;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psfa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd_ready = 1'b0;
		accept    = 1'b0;
		unique case (state_q)
			psfa_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				accept    = cmd_valid;
				if (accept) begin
					cmd.capture = 1'b1;
					if (opcode == psfa_pkg::OP_READ) begin
						state_d = psfa_pkg::ST_AVG;
					end else begin
						state_d = psfa_pkg::ST_SAMPLE;
					end
				end
			end
			psfa_pkg::ST_SAMPLE: begin
				cmd.sample_commit = 1'b1;
				state_d           = psfa_pkg::ST_OUT;
			end
			psfa_pkg::ST_AVG: begin
				cmd.avg_capture = 1'b1;
				state_d         = psfa_pkg::ST_MUL;
			end
			psfa_pkg::ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = psfa_pkg::ST_SPAN_START;
			end
			psfa_pkg::ST_SPAN_START: begin
				cmd.span_start = 1'b1;
				state_d        = psfa_pkg::ST_SPAN_DIV;
			end
			psfa_pkg::ST_SPAN_DIV: begin
				if (!status.div_busy) begin
					cmd.p_capture = 1'b1;
					state_d       = psfa_pkg::ST_SPLIT;
				end
			end
			psfa_pkg::ST_SPLIT: begin
				cmd.whole_capture = 1'b1;
				state_d           = psfa_pkg::ST_OUT;
			end
			psfa_pkg::ST_OUT: begin
				// wait here only while the previous result is still held
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = psfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psfa_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ sv/psfa_checker.sv @@
`include "assert_macros.svh"

module psfa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       sample_dropped,
	input logic [9:0] average_raw,
	input logic [6:0] pressure_whole,
	input logic [6:0] pressure_hundredths
);

	`PSFA_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_dropped) && $stable(average_raw) && $stable(pressure_whole) && $stable(pressure_hundredths), "response changed before its transaction completed")
	`PSFA_ASSERT(a_drop_clean, clk, arst_n, rsp_valid && sample_dropped |-> average_raw == 10'd0 && pressure_whole == 7'd0 && pressure_hundredths == 7'd0, "dropped sample carries read fields")
	`PSFA_ASSERT(a_range, clk, arst_n, rsp_valid |-> pressure_whole <= 7'd99 && pressure_hundredths <= 7'd99, "pressure digits out of range")
	`PSFA_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind pressure_spike_filter_averager psfa_checker u_psfa_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.pready             (pready),
	.rsp_valid          (rsp_valid),
	.rsp_ready          (rsp_ready),
	.sample_dropped     (sample_dropped),
	.average_raw        (average_raw),
	.pressure_whole     (pressure_whole),
	.pressure_hundredths(pressure_hundredths)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int RING_DEPTH = 8;
	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AFTER = 120;

	typedef struct packed {
		logic       dropped;
		logic [9:0] avg;
		logic [6:0] whole;
		logic [6:0] hund;
	} reading_t;

	class pressure_scoreboard;
		psfa_pkg::cfg_t cfg;
		logic [9:0]  ring [RING_DEPTH];
		int unsigned ring_sum;
		int unsigned wr_pos;
		logic [3:0]  spike_cnt;
		logic [9:0]  ref_avg;
		reading_t    readings_q[$];
		int          errors;

		function new();
			cfg.cal_low = psfa_pkg::CAL_LOW_RST;
			cfg.cal_high = psfa_pkg::CAL_HIGH_RST;
			cfg.full_scale = psfa_pkg::FULL_SCALE_RST;
			cfg.spike_thr = psfa_pkg::SPIKE_THR_RST;
			cfg.max_spikes = psfa_pkg::MAX_SPIKES_RST;
			foreach (ring[i]) ring[i] = '0;
			ring_sum = 0;
			wr_pos = 0;
			spike_cnt = '0;
			ref_avg = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				psfa_pkg::REG_CAL_LOW: cfg.cal_low = value[9:0];
				psfa_pkg::REG_CAL_HIGH: cfg.cal_high = value[10:0];
				psfa_pkg::REG_FULL_SCALE: cfg.full_scale = value[13:0];
				psfa_pkg::REG_SPIKE_THR: cfg.spike_thr = value[9:0];
				psfa_pkg::REG_MAX_SPIKES: cfg.max_spikes = value[3:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				psfa_pkg::REG_CAL_LOW: return 32'(cfg.cal_low);
				psfa_pkg::REG_CAL_HIGH: return 32'(cfg.cal_high);
				psfa_pkg::REG_FULL_SCALE: return 32'(cfg.full_scale);
				psfa_pkg::REG_SPIKE_THR: return 32'(cfg.spike_thr);
				psfa_pkg::REG_MAX_SPIKES: return 32'(cfg.max_spikes);
				default: return '0;
			endcase
		endfunction

		function int unsigned to_hundredths(int unsigned avg);
			int unsigned fs;
			int unsigned lo;
			int unsigned hi;
			int unsigned p;
			fs = (cfg.full_scale > psfa_pkg::FULL_SCALE_MAX) ?
				psfa_pkg::FULL_SCALE_MAX : cfg.full_scale;
			lo = cfg.cal_low;
			hi = cfg.cal_high;
			if (hi <= lo || avg <= lo)
				return 0;
			p = (avg - lo) * fs / (hi - lo);
			return (p > fs) ? fs : p;
		endfunction

		function void note_cmd(logic op, logic [9:0] s);
			reading_t    r;
			int unsigned sv;
			int unsigned rv;
			int unsigned diff;
			int unsigned p;
			r = '0;
			sv = s;
			rv = ref_avg;
			if (op == psfa_pkg::OP_SAMPLE) begin
				diff = (sv > rv) ? sv - rv : rv - sv;
				if (rv != 0 && diff > cfg.spike_thr && spike_cnt < cfg.max_spikes) begin
					spike_cnt = spike_cnt + 4'd1;
					r.dropped = 1'b1;
				end else begin
					spike_cnt = '0;
					ring_sum = ring_sum - ring[wr_pos] + sv;
					ring[wr_pos] = s;
					wr_pos = (wr_pos + 1) % RING_DEPTH;
				end
			end else begin
				ref_avg = 10'(ring_sum / RING_DEPTH);
				p = to_hundredths(ref_avg);
				r.avg = ref_avg;
				r.whole = 7'(p / psfa_pkg::HUNDRED);
				r.hund = 7'(p % psfa_pkg::HUNDRED);
			end
			readings_q.push_back(r);
		endfunction

		function void check_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_rsp(reading_t got);
			reading_t exp_r;
			if (readings_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = readings_q.pop_front();
			check_field("sample_dropped", 10'(exp_r.dropped), 10'(got.dropped));
			check_field("average_raw", exp_r.avg, got.avg);
			check_field("pressure_whole", 10'(exp_r.whole), 10'(got.whole));
			check_field("pressure_hundredths", 10'(exp_r.hund), 10'(got.hund));
		endfunction

		function int pending();
			return readings_q.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [psfa_pkg::ADDR_W-1:0]   paddr;
	logic [psfa_pkg::DATA_W-1:0]   pwdata;
	logic [psfa_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          cmd_valid;
	logic                          cmd_ready;
	logic                          opcode;
	logic [9:0]                    sample;
	logic                          rsp_valid;
	logic                          rsp_ready;
	logic                          sample_dropped;
	logic [9:0]                    average_raw;
	logic [6:0]                    pressure_whole;
	logic [6:0]                    pressure_hundredths;

	bit                  quiet;
	pressure_scoreboard  sb;

	pressure_spike_filter_averager #(
		.RING_DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.opcode(opcode),
		.sample(sample),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sample_dropped(sample_dropped),
		.average_raw(average_raw),
		.pressure_whole(pressure_whole),
		.pressure_hundredths(pressure_hundredths)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic apb_readback(logic [2:0] idx);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== sb.reg_value(idx)) begin
			$display("%0t: register %0d readback, expected %0d actual %0d",
				$time, idx, sb.reg_value(idx), got);
			sb.errors++;
		end
	endtask

	task automatic configure(logic [31:0] lo, logic [31:0] hi, logic [31:0] fs,
			logic [31:0] thr, logic [31:0] maxs);
		logic [31:0] vals [5];
		logic [2:0]  idxs [5];
		vals = '{lo, hi, fs, thr, maxs};
		idxs = '{psfa_pkg::REG_CAL_LOW, psfa_pkg::REG_CAL_HIGH, psfa_pkg::REG_FULL_SCALE,
			psfa_pkg::REG_SPIKE_THR, psfa_pkg::REG_MAX_SPIKES};
		foreach (idxs[i]) begin
			apb_write(idxs[i], vals[i]);
			apb_readback(idxs[i]);
		end
	endtask

	// offer one transaction, then maybe idle for a burst
	task automatic issue(logic op, logic [9:0] s);
		cmd_valid <= 1'b1;
		opcode <= op;
		sample <= s;
		do @(posedge clk); while (!cmd_ready);
		sb.note_cmd(op, s);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int r;
		int s;
		int thr;
		repeat (n) begin
			r = $urandom_range(0, 99);
			thr = sb.cfg.spike_thr;
			if (r < 15) begin
				issue(psfa_pkg::OP_READ, 10'($urandom));
			end else if (r < 70) begin
				// mostly near the reference, so the spike path sees both outcomes
				s = int'(sb.ref_avg) + int'($urandom_range(0, 2 * thr + 2)) - thr - 1;
				if (s < 0) s = 0;
				if (s > 1023) s = 1023;
				issue(psfa_pkg::OP_SAMPLE, 10'(s));
			end else if (r < 92) begin
				issue(psfa_pkg::OP_SAMPLE, 10'($urandom_range(0, 1023)));
			end else begin
				issue(psfa_pkg::OP_SAMPLE, $urandom_range(0, 1) ? 10'h3FF : 10'h000);
			end
		end
	endtask

	task automatic directed();
		issue(psfa_pkg::OP_READ, 10'h3FF);
		repeat (8) issue(psfa_pkg::OP_SAMPLE, 10'h3FF);
		issue(psfa_pkg::OP_READ, 10'h000);
		// five spikes dropped, the sixth goes into the ring
		repeat (6) issue(psfa_pkg::OP_SAMPLE, 10'h000);
		issue(psfa_pkg::OP_SAMPLE, 10'd972);
		issue(psfa_pkg::OP_SAMPLE, 10'd973);
		issue(psfa_pkg::OP_READ, 10'h155);
		issue(psfa_pkg::OP_SAMPLE, 10'h2AA);
		issue(psfa_pkg::OP_SAMPLE, 10'h155);
		issue(psfa_pkg::OP_SAMPLE, 10'd512);
		issue(psfa_pkg::OP_READ, 10'h2AA);
	endtask

	task automatic random_config();
		configure($urandom_range(0, 1023), $urandom_range(1, 2047), $urandom_range(1, 9999),
			$urandom_range(0, 150), $urandom_range(0, 15));
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		opcode = psfa_pkg::OP_SAMPLE;
		sample = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		wait_idle();

		configure(32'd0, 32'd2047, 32'd9999, 32'd0, 32'd15);
		run_random(100);
		wait_idle();

		// inverted calibration, spike check never fires
		configure(32'd1023, 32'd1, 32'd1, 32'd1023, 32'd0);
		run_random(60);
		wait_idle();

		// oversized writes: upper bits dropped, full scale above its range
		configure(32'hABCD_0064, 32'd900, 32'hFFFF_FFFF, 32'd20, 32'd3);
		apb_write(REG_UNUSED, $urandom);
		run_random(100);
		wait_idle();

		repeat (2) begin
			random_config();
			run_random(80);
			wait_idle();
		end

		quiet = 1'b1;
		random_config();
		run_random(80);
		wait_idle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		int       n_rsp;
		int       stall;
		bit       held;
		reading_t got;
		n_rsp = 0;
		stall = 0;
		held = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				got = {sample_dropped, average_raw, pressure_whole, pressure_hundredths};
				sb.check_rsp(got);
				n_rsp++;
			end
			if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else if (!held && n_rsp >= HOLD_AFTER) begin
				// long hold-off so the block backs up into its input
				held = 1'b1;
				stall = LONG_HOLD - 1;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
